/* design/stbs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared constants, codes and types of the sorted table binary search core.
// ----------------------------------------------------------------------------
package stbs_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int DATA_WIDTH_DEF  = 32;

  localparam int IN_IDX_W  = 10;
  localparam int IN_DATA_W = 32;
  localparam int LEN_CFG_W = 11;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  localparam logic [PADDR_W-3:0] REG_ARRAY_LENGTH = '0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_DONE
  } stbs_state_t;

  typedef struct packed {
    logic                found;
    logic [IN_IDX_W-1:0] match_index;
  } stbs_result_t;

endpackage

/* design/stbs_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_cfg
// APB-style register file holding the number of sorted entries in use.
// ----------------------------------------------------------------------------
module stbs_cfg import stbs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready,
  output logic [LEN_CFG_W-1:0] array_length
);

  logic [LEN_CFG_W-1:0] len_r;
  logic [LEN_CFG_W-1:0] len_nxt;
  logic                 sel_len;

  assign sel_len = (paddr[PADDR_W-1:2] == REG_ARRAY_LENGTH);
  assign pready  = 1'b1;

  always_comb begin
    len_nxt = len_r;
    if (psel && penable && pwrite && sel_len) begin
      len_nxt = pwdata[LEN_CFG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else begin
      len_r <= len_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_len) begin
      prdata = PDATA_W'(len_r);
    end
  end

  assign array_length = len_r;

endmodule

/* design/stbs_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_mem
// Single-port-write, single-port-read table memory with registered read data.
// ----------------------------------------------------------------------------
module stbs_mem import stbs_pkg::*; #(
  parameter  int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter  int DATA_WIDTH  = DATA_WIDTH_DEF,
  localparam int IDX_W       = $clog2(TABLE_DEPTH)
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [IDX_W-1:0]      waddr,
  input  logic [DATA_WIDTH-1:0] wdata,
  input  logic [IDX_W-1:0]      raddr,
  output logic [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [TABLE_DEPTH];
  logic [DATA_WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* design/stbs_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_ctrl
// Search sequencer: one probe address and one signed compare per step,
// narrowing the interval until the key is found or the interval is empty.
// ----------------------------------------------------------------------------
module stbs_ctrl import stbs_pkg::*; #(
  parameter  int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter  int DATA_WIDTH  = DATA_WIDTH_DEF,
  localparam int IDX_W       = $clog2(TABLE_DEPTH),
  localparam int LEN_W       = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_req_type,
  input  logic [IN_IDX_W-1:0]         in_entry_index,
  input  logic signed [IN_DATA_W-1:0] in_data_value,
  input  logic [LEN_CFG_W-1:0]        array_length,
  output logic                        out_valid,
  input  logic                        out_stall,
  output stbs_result_t                out_res,
  output logic                        mem_we,
  output logic [IDX_W-1:0]            mem_waddr,
  output logic [DATA_WIDTH-1:0]       mem_wdata,
  output logic [IDX_W-1:0]            mem_raddr,
  input  logic [DATA_WIDTH-1:0]       mem_rdata
);

  stbs_state_t           state_r, state_nxt;
  logic [LEN_W-1:0]      lo_r, lo_nxt;
  logic [LEN_W-1:0]      hi_r, hi_nxt;
  logic [IDX_W-1:0]      mid_r, mid_nxt;
  logic [DATA_WIDTH-1:0] key_r, key_nxt;
  logic                  hit_r, hit_nxt;
  logic                  out_valid_r, out_valid_nxt;
  stbs_result_t          out_res_r, out_res_nxt;

  logic                  idle;
  logic [LEN_W-1:0]      len_sat;
  logic [LEN_W-1:0]      span;
  logic [LEN_W-1:0]      mid_calc;
  logic                  in_range;
  logic                  probe_eq;
  logic                  probe_gt;
  logic                  out_free;

  assign idle     = (state_r == ST_IDLE);
  assign in_stall = !idle;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    if (32'(array_length) > 32'(TABLE_DEPTH)) begin
      len_sat = LEN_W'(TABLE_DEPTH);
    end else begin
      len_sat = LEN_W'(array_length);
    end
  end

  assign span     = hi_r - lo_r - LEN_W'(1);
  assign mid_calc = lo_r + (span >> 1);
  assign in_range = (32'(in_entry_index) < 32'(TABLE_DEPTH));
  assign probe_eq = (mem_rdata == key_r);
  assign probe_gt = ($signed(mem_rdata) > $signed(key_r));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && (in_req_type == REQ_SEARCH)) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (lo_r < hi_r) begin
          state_nxt = ST_CMP;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_CMP: begin
        if (probe_eq) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    key_nxt       = key_r;
    hit_nxt       = hit_r;
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r && out_stall;
    mem_we        = 1'b0;
    mem_waddr     = IDX_W'(in_entry_index);
    mem_wdata     = DATA_WIDTH'($unsigned(in_data_value));
    mem_raddr     = IDX_W'(mid_calc);
    case (state_r)
      ST_IDLE: begin
        if (in_valid && (in_req_type == REQ_SEARCH)) begin
          lo_nxt  = '0;
          hi_nxt  = len_sat;
          key_nxt = DATA_WIDTH'($unsigned(in_data_value));
          hit_nxt = 1'b0;
        end else if (in_valid && in_range) begin
          mem_we = 1'b1;
        end
      end
      ST_READ: begin
        mid_nxt = IDX_W'(mid_calc);
      end
      ST_CMP: begin
        if (probe_eq) begin
          hit_nxt = 1'b1;
        end else if (probe_gt) begin
          hi_nxt = LEN_W'(mid_r);
        end else begin
          lo_nxt = LEN_W'(mid_r) + LEN_W'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt         = 1'b1;
          out_res_nxt.found     = hit_r;
          out_res_nxt.match_index = hit_r ? IN_IDX_W'(mid_r) : '0;
        end
      end
      default: begin
        hit_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    mid_r     <= mid_nxt;
    key_r     <= key_nxt;
    hit_r     <= hit_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

/* design/sorted_table_binary_search_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_binary_search_core
// Table of signed words loaded in ascending order, searched by bisection.
// ----------------------------------------------------------------------------
// The input channel carries write and search items. A write item stores
// data_value at entry_index, gives no result, and the next item may follow
// in the very next cycle. A search item looks for data_value among the first
// array_length entries, capped at TABLE_DEPTH, and gives one result transfer
// with found and match_index.
// A search holds the input channel stalled while it runs. Each probe has two
// steps, a READ state that addresses the table memory and a CMP state for the
// signed compare; the search ends in a DONE state that registers the result,
// and only after the return to idle is the next item taken. The single memory
// read port allows one probe at a time.
// The result sits in an output register. While the receiver stalls it holds
// its value, and further write items are still taken; a second search waits
// for the register to empty before presenting its result.
// array_length is written through the APB-style port; the user must write it
// only while idle (not enforced by the block). Reset clears the sequencer, the
// output register and array_length; the table is undefined until written.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_core import stbs_pkg::*; #(
  parameter  int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter  int DATA_WIDTH  = DATA_WIDTH_DEF,
  localparam int IDX_W       = $clog2(TABLE_DEPTH)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_req_type,
  input  logic [IN_IDX_W-1:0]         in_entry_index,
  input  logic signed [IN_DATA_W-1:0] in_data_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_found,
  output logic [IN_IDX_W-1:0]         out_match_index,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [PADDR_W-1:0]          paddr,
  input  logic [PDATA_W-1:0]          pwdata,
  output logic [PDATA_W-1:0]          prdata,
  output logic                        pready
);

  logic [LEN_CFG_W-1:0]  array_length;
  stbs_result_t          res;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [IDX_W-1:0]      mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  stbs_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .array_length (array_length)
  );

  stbs_mem #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  stbs_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_entry_index (in_entry_index),
    .in_data_value  (in_data_value),
    .array_length   (array_length),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_res        (res),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata)
  );

  assign out_found       = res.found;
  assign out_match_index = res.match_index;

endmodule

/* design/stbs_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_chk
// Port-level checks of the search core, bound to the top level.
// ----------------------------------------------------------------------------
module stbs_chk import stbs_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                in_req_type,
  input logic                out_valid,
  input logic                out_stall,
  input logic                out_found,
  input logic [IN_IDX_W-1:0] out_match_index
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_found)
      && $stable(out_match_index))
    else $error("Stalled result transfer changed.");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_match_index == '0)
    else $error("Missed search reported a non-zero index.");

  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_req_type == REQ_SEARCH) |=> in_stall)
    else $error("Input taken while a search was running.");

  a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_req_type == REQ_WRITE) |=> !in_stall)
    else $error("Write transfer stalled the input channel.");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("Block not empty after reset.");

endmodule

bind sorted_table_binary_search_core stbs_chk u_stbs_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_req_type     (in_req_type),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_found       (out_found),
  .out_match_index (out_match_index)
);

/* bench/stbs_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_checker
// Watches the sorted table search core, predicts each search result and
// compares it with the result transfers that the core delivers.
// ----------------------------------------------------------------------------
module stbs_checker import stbs_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        in_req_type,
  input  logic [IN_IDX_W-1:0]         in_entry_index,
  input  logic signed [IN_DATA_W-1:0] in_data_value,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic                        out_found,
  input  logic [IN_IDX_W-1:0]         out_match_index,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [PADDR_W-1:0]          paddr,
  input  logic [PDATA_W-1:0]          pwdata,
  input  logic                        pready,
  output int                          fail_count,
  output int                          outstanding,
  output int                          hits_seen,
  output int                          misses_seen
);

  localparam int DEPTH = TABLE_DEPTH_DEF;

  logic signed [IN_DATA_W-1:0] entries [DEPTH];
  logic [LEN_CFG_W-1:0]        active_length;
  stbs_result_t                pending_results [$];
  int                          results_seen;

  function automatic stbs_result_t search_table(input logic signed [IN_DATA_W-1:0] key);
    int           lo;
    int           hi;
    int           mid;
    stbs_result_t res;
    res = '0;
    lo  = 0;
    hi  = (int'(active_length) > DEPTH) ? DEPTH - 1 : int'(active_length) - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (entries[mid] == key) begin
        res.found       = 1'b1;
        res.match_index = mid[IN_IDX_W-1:0];
        break;
      end
      if (entries[mid] > key) hi = mid - 1;
      else lo = mid + 1;
    end
    return res;
  endfunction

  task automatic log_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin : watch
    stbs_result_t want;
    if (!rst_n) begin
      pending_results.delete();
      active_length = '0;
      fail_count    = 0;
      hits_seen     = 0;
      misses_seen   = 0;
      results_seen  = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_ARRAY_LENGTH) begin
        active_length = pwdata[LEN_CFG_W-1:0];
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          log_failure($sformatf("Unexpected result %0d: found=%0b index=%0d",
                                results_seen, out_found, out_match_index));
        end else begin
          want = pending_results.pop_front();
          if (want.found !== out_found || want.match_index !== out_match_index) begin
            log_failure($sformatf(
              "Mismatch on result %0d: expected found=%0b index=%0d, got found=%0b index=%0d",
              results_seen, want.found, want.match_index, out_found, out_match_index));
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_req_type == REQ_WRITE) begin
          if (int'(in_entry_index) < DEPTH) entries[in_entry_index] = in_data_value;
        end else begin
          want = search_table(in_data_value);
          if (want.found) hits_seen++;
          else misses_seen++;
          pending_results.push_back(want);
        end
      end
    end
    outstanding = pending_results.size();
  end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the sorted table binary search core: loads sorted
// tables of many lengths, sets the search length through the register port
// and runs directed and random search and write traffic under varied idling,
// while a checker predicts and compares every result transfer.
// ----------------------------------------------------------------------------
module tb;
  import stbs_pkg::*;

  localparam int     DEPTH           = TABLE_DEPTH_DEF;
  localparam int     PHASES          = 9;
  localparam int     ITEMS_PER_PHASE = 56;
  localparam int     HOLD_CYCLES     = 400;
  localparam int     SETTLE_CYCLES   = 30;
  localparam longint DATA_MAX        = 64'h7FFF_FFFF;
  localparam longint DATA_MIN        = -DATA_MAX - 1;

  logic                        clk             = 1'b0;
  logic                        rst_n           = 1'b0;
  logic                        in_valid        = 1'b0;
  logic                        in_stall;
  logic                        in_req_type     = REQ_WRITE;
  logic [IN_IDX_W-1:0]         in_entry_index  = '0;
  logic signed [IN_DATA_W-1:0] in_data_value   = '0;
  logic                        out_valid;
  logic                        out_stall       = 1'b0;
  logic                        out_found;
  logic [IN_IDX_W-1:0]         out_match_index;
  logic                        psel            = 1'b0;
  logic                        penable         = 1'b0;
  logic                        pwrite          = 1'b0;
  logic [PADDR_W-1:0]          paddr           = '0;
  logic [PDATA_W-1:0]          pwdata          = '0;
  logic [PDATA_W-1:0]          prdata;
  logic                        pready;

  int fail_count;
  int outstanding;
  int hits_seen;
  int misses_seen;

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  bit pressure_on  = 1'b0;
  bit hold_done    = 1'b0;
  int hold_left    = 0;
  int n_writes     = 0;
  int n_searches   = 0;
  int n_settings   = 0;

  logic signed [IN_DATA_W-1:0] shadow [DEPTH];

  sorted_table_binary_search_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_entry_index  (in_entry_index),
    .in_data_value   (in_data_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_found       (out_found),
    .out_match_index (out_match_index),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  stbs_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_entry_index  (in_entry_index),
    .in_data_value   (in_data_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_found       (out_found),
    .out_match_index (out_match_index),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .hits_seen       (hits_seen),
    .misses_seen     (misses_seen)
  );

  always #5 clk = ~clk;

  // The long hold-off keeps the output register full, so that a later search waits behind it.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (pressure_on && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_item(input logic req, input logic [IN_IDX_W-1:0] idx,
                           input logic signed [IN_DATA_W-1:0] data);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_entry_index <= idx;
    in_data_value  <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (req == REQ_WRITE) begin
      shadow[idx] = data;
      n_writes++;
    end else begin
      n_searches++;
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_length(input logic [LEN_CFG_W-1:0] len);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_ARRAY_LENGTH, 2'b00};
    pwdata  <= PDATA_W'(len);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    n_settings++;
  endtask

  task automatic load_sorted(input int count);
    longint stride;
    longint acc;
    bit     pin_ends;
    stride   = 64'd4294967296 / (count + 1);
    pin_ends = ($urandom_range(0, 3) == 0);
    acc      = pin_ends ? DATA_MIN : DATA_MIN + longint'($urandom_range(0, 32'(stride - 1)));
    for (int i = 0; i < count; i++) begin
      if (i > 0 && $urandom_range(0, 7) != 0) begin
        acc += 1 + longint'($urandom_range(0, 32'(2 * stride - 2)));
      end
      if (acc > DATA_MAX || (pin_ends && i == count - 1)) acc = DATA_MAX;
      send_item(REQ_WRITE, i[IN_IDX_W-1:0], acc[IN_DATA_W-1:0]);
    end
  endtask

  initial begin
    int                          plan [PHASES];
    int                          span;
    int                          pick;
    int                          idx;
    logic signed [IN_DATA_W-1:0] key;

    plan = '{37, 1024, 2047, 1, 2, 0, 1023, 600, 0};
    plan[PHASES-1] = $urandom_range(3, 300);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty length, extremes, duplicates, absent keys, a single entry.
    send_item(REQ_SEARCH, '0, $urandom);
    send_item(REQ_WRITE, 10'd0, 32'sh8000_0000);
    send_item(REQ_WRITE, 10'd1, -32'sd5);
    send_item(REQ_WRITE, 10'd2, 32'sd0);
    send_item(REQ_WRITE, 10'd3, 32'sd7);
    send_item(REQ_WRITE, 10'd4, 32'sd7);
    send_item(REQ_WRITE, 10'd5, 32'sd7);
    send_item(REQ_WRITE, 10'd6, 32'sd100);
    send_item(REQ_WRITE, 10'd7, 32'sh7FFF_FFFF);
    send_item(REQ_WRITE, 10'd1023, -32'sd1);
    settle();
    write_length(11'd8);
    send_item(REQ_SEARCH, '0, 32'sh8000_0000);
    send_item(REQ_SEARCH, '0, 32'sh7FFF_FFFF);
    send_item(REQ_SEARCH, '0, 32'sd7);
    send_item(REQ_SEARCH, '0, 32'sd0);
    send_item(REQ_SEARCH, '0, -32'sd5);
    send_item(REQ_SEARCH, '0, 32'sd3);
    send_item(REQ_SEARCH, '0, 32'sd101);
    send_item(REQ_SEARCH, '0, 32'sh8000_0001);
    settle();
    write_length(11'd1);
    send_item(REQ_SEARCH, '0, 32'sh8000_0000);
    send_item(REQ_SEARCH, '0, 32'sh7FFF_FFFF);
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      span = (plan[ph] > DEPTH) ? DEPTH : plan[ph];
      case (ph % 4)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct  = 68;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 68;
        end
        default: begin
          tx_idle_pct  = 17;
          rx_stall_pct = 17;
        end
      endcase
      load_sorted(span);
      settle();
      write_length(plan[ph][LEN_CFG_W-1:0]);
      if (ph == 1) pressure_on = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 99);
        idx  = (span > 0) ? $urandom_range(0, span - 1) : 0;
        if (pick < 20) begin
          idx = $urandom_range(0, DEPTH - 1);
          key = (idx < span && $urandom_range(0, 3) != 0) ? shadow[idx] : $urandom;
          send_item(REQ_WRITE, idx[IN_IDX_W-1:0], key);
        end else begin
          if (span > 0 && pick < 65) key = shadow[idx];
          else if (span > 0 && pick < 85) key = shadow[idx] + ($urandom_range(0, 1) ? 1 : -1);
          else key = $urandom;
          send_item(REQ_SEARCH, IN_IDX_W'($urandom), key);
        end
      end
      settle();
    end

    $display("Covered %0d searches (%0d hits, %0d misses) and %0d table writes",
             n_searches, hits_seen, misses_seen, n_writes);
    $display("over %0d length settings up to 2047, with a %0d-cycle receiver hold-off.",
             n_settings, HOLD_CYCLES);
    if (fail_count == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sorted_table_binary_search_core.f */
design/stbs_pkg.sv
design/stbs_cfg.sv
design/stbs_mem.sv
design/stbs_ctrl.sv
design/sorted_table_binary_search_core.sv
design/stbs_chk.sv
bench/stbs_checker.sv
bench/tb.sv
